@@ hw/rtl/linear_probe_hash_table_assert.svh @@
// Assertion macros for the hash table checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// checked while out of reset
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define LPHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lpht_pkg.sv @@
// Package for the linear probe hash table: codes, sizes, sequencer states.
// No dependencies.
package lpht_pkg;

  localparam int CAPACITY    = 256;
  localparam int KEY_BYTES   = 4;
  localparam int VALUE_BYTES = 4;

  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  // prime is 2^40 + 435
  localparam int          FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_LOW   = 9'd435;

  localparam logic [8:0] MAX_ENTRIES_RST = 9'd181;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_REM   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_NF    = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam int WORD_W = 66;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_HASH, ST_MOD, ST_RD, ST_CHK, ST_DONE
  } state_t;

  function automatic logic [31:0] byte_mask32(input int nbytes);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      if (b < nbytes) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/lpht_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/linear_probe_hash_table.sv @@
// Linear probe hash table: put, get, remove and clear on 32-bit keys/values.
// Depends on lpht_pkg and lpht_ram.
//
// Use:
//  in_*  : command beats. in_tuser = cmd, in_tdata = key | value.
//  out_* : one result beat per command. out_tuser = status,
//          out_tdata = read_value | live_count.
//  cfg_* : write of max_entries, taken on any cycle with cfg_wen high.
// Steps per command (one at a time, in_tready low while busy):
//  hashing of the KEY_BYTES key bytes (xor, then multiply by the FNV prime
//  2^40 + 435) through one shared multiply-add step, then, when CAPACITY is
//  not a power of two, a remainder over the hash bytes (reciprocal multiply,
//  then multiply back and subtract, per byte), then a read (ST_RD) and a
//  check (ST_CHK) per probed slot (single RAM port, registered read), then
//  ST_DONE loads the output register once it is free.
// Clear and reset both sweep the slot RAM, one slot a cycle;
// no command is taken during the sweep.
// A finished result waits in the output register while the receiver stalls;
// the next command is still accepted, but its result waits until that beat
// has gone.
module linear_probe_hash_table #(
  parameter int CAPACITY = lpht_pkg::CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], live_count[40:32], zero
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wen,
  input  logic [8:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam int V_W = IDX_W + 8;
  localparam logic [V_W-1:0] CAP_V = V_W'(CAPACITY);
  localparam logic [8:0]     RECIP = 9'((1 << V_W) / CAPACITY);

  lpht_pkg::state_t state_r, state_nxt;

  logic [1:0]       cmd_r, cmd_nxt;
  logic [31:0]      key_r, key_nxt, val_r, val_nxt;
  logic [63:0]      hash_r, hash_nxt;
  logic [5:0]       step_r, step_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [V_W+8:0]   mprod_r, mprod_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt, cnt_r, cnt_nxt, tomb_r, tomb_nxt;
  logic             have_tomb_r, have_tomb_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [8:0]       max_r;
  logic             init_r, init_nxt;
  logic [1:0]       res_sts_r, res_sts_nxt;
  logic [31:0]      res_rd_r, res_rd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_sts_r, out_sts_nxt;
  logic [31:0]      out_rd_r, out_rd_nxt;
  logic [8:0]       out_cnt_r, out_cnt_nxt;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_addr;
  logic [lpht_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  logic [63:0]  hx, hmul, hfin;
  logic [7:0]   kbyte;
  logic [7:0]   mbyte, mq;
  logic [V_W-1:0] mv, mr0, mr1;
  logic [1:0]   rd_st;
  logic [31:0]  rd_key, rd_val;
  logic         last, key_hit, is_full;
  logic [IDX_W-1:0] slot_inc;

  lpht_ram #(.WIDTH(lpht_pkg::WORD_W), .DEPTH(CAPACITY)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // shared hash step: (h ^ b) * (2^40 + 435)
  assign kbyte = (step_r < 6'd4) ? 8'(key_r >> {step_r[1:0], 3'b000}) : 8'h00;
  assign hx    = hash_r ^ {56'd0, kbyte};
  assign hmul  = (hx << lpht_pkg::FNV_SHIFT) + 64'(hx * {55'd0, lpht_pkg::FNV_LOW});
  assign hfin  = (hmul == 64'd0) ? 64'd1 : hmul;

  // remainder, top hash byte first: r = (r * 256 + byte) mod CAPACITY
  assign mbyte = 8'(hash_r >> {~step_r[3:1], 3'b000});
  assign mv    = {rem_r, mbyte};
  assign mq    = mprod_r[V_W +: 8];
  assign mr0   = mv - V_W'(mq) * CAP_V;
  assign mr1   = (mr0 >= CAP_V) ? mr0 - CAP_V : mr0;

  assign rd_st   = ram_rdata[65:64];
  assign rd_key  = ram_rdata[63:32];
  assign rd_val  = ram_rdata[31:0];
  assign last    = cnt_r == LAST_IDX;
  assign key_hit = rd_st == lpht_pkg::SLOT_USED && rd_key == key_r;
  assign is_full = CMP_W'(count_r) >= CMP_W'(max_r);
  assign slot_inc = (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;

  assign in_tready  = state_r == lpht_pkg::ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_rd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::ST_CLR;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      count_r     <= '0;
      max_r       <= lpht_pkg::MAX_ENTRIES_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    hash_r      <= hash_nxt;
    step_r      <= step_nxt;
    rem_r       <= rem_nxt;
    mprod_r     <= mprod_nxt;
    slot_r      <= slot_nxt;
    tomb_r      <= tomb_nxt;
    have_tomb_r <= have_tomb_nxt;
    res_sts_r   <= res_sts_nxt;
    res_rd_r    <= res_rd_nxt;
    out_sts_r   <= out_sts_nxt;
    out_rd_r    <= out_rd_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    hash_nxt      = hash_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    mprod_nxt     = mprod_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    tomb_nxt      = tomb_r;
    have_tomb_nxt = have_tomb_r;
    count_nxt     = count_r;
    res_sts_nxt   = res_sts_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sts_nxt   = out_sts_r;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_addr      = slot_r;
    ram_wdata     = {lpht_pkg::SLOT_USED, key_r, val_r};

    case (state_r)
      lpht_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_r;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt     = '0;
          count_nxt   = '0;
          init_nxt    = 1'b0;
          res_sts_nxt = lpht_pkg::STS_OK;
          res_rd_nxt  = '0;
          state_nxt   = init_r ? lpht_pkg::ST_IDLE : lpht_pkg::ST_DONE;
        end
      end
      lpht_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = in_tuser;
          key_nxt       = in_tdata[31:0] & lpht_pkg::byte_mask32(lpht_pkg::KEY_BYTES);
          val_nxt       = in_tdata[63:32] & lpht_pkg::byte_mask32(lpht_pkg::VALUE_BYTES);
          hash_nxt      = lpht_pkg::FNV_BASIS;
          step_nxt      = '0;
          cnt_nxt       = '0;
          have_tomb_nxt = 1'b0;
          state_nxt     = (in_tuser == lpht_pkg::CMD_CLEAR) ? lpht_pkg::ST_CLR
                                                           : lpht_pkg::ST_HASH;
        end
      end
      lpht_pkg::ST_HASH: begin
        hash_nxt = hmul;
        step_nxt = step_r + 1'b1;
        if (step_r == 6'(lpht_pkg::KEY_BYTES - 1)) begin
          hash_nxt = hfin;
          step_nxt = '0;
          rem_nxt  = '0;
          slot_nxt = hfin[IDX_W-1:0];
          state_nxt = IS_POW2 ? lpht_pkg::ST_RD : lpht_pkg::ST_MOD;
        end
      end
      lpht_pkg::ST_MOD: begin
        step_nxt = step_r + 1'b1;
        if (!step_r[0]) begin
          mprod_nxt = (V_W + 9)'(mv) * (V_W + 9)'(RECIP);
        end else begin
          rem_nxt = mr1[IDX_W-1:0];
          if (step_r == 6'd15) begin
            slot_nxt  = mr1[IDX_W-1:0];
            state_nxt = lpht_pkg::ST_RD;
          end
        end
      end
      lpht_pkg::ST_RD: begin
        state_nxt = lpht_pkg::ST_CHK;
      end
      lpht_pkg::ST_CHK: begin
        res_rd_nxt = '0;
        slot_nxt   = slot_inc;
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = lpht_pkg::ST_RD;
        if (cmd_r == lpht_pkg::CMD_PUT) begin
          if (key_hit) begin
            ram_we      = 1'b1;
            res_sts_nxt = lpht_pkg::STS_OK;
            state_nxt   = lpht_pkg::ST_DONE;
          end else if (rd_st == lpht_pkg::SLOT_EMPTY || last) begin
            state_nxt = lpht_pkg::ST_DONE;
            if (rd_st == lpht_pkg::SLOT_TOMB && !have_tomb_r) begin
              have_tomb_nxt = 1'b1;
              tomb_nxt      = slot_r;
            end
            if (is_full || (rd_st != lpht_pkg::SLOT_EMPTY && !have_tomb_nxt)) begin
              res_sts_nxt = lpht_pkg::STS_FULL;
            end else begin
              ram_we      = 1'b1;
              ram_addr    = have_tomb_nxt ? tomb_nxt : slot_r;
              count_nxt   = count_r + 1'b1;
              res_sts_nxt = lpht_pkg::STS_OK;
            end
          end else if (rd_st == lpht_pkg::SLOT_TOMB && !have_tomb_r) begin
            have_tomb_nxt = 1'b1;
            tomb_nxt      = slot_r;
          end
        end else begin
          if (key_hit) begin
            res_sts_nxt = lpht_pkg::STS_OK;
            res_rd_nxt  = rd_val;
            state_nxt   = lpht_pkg::ST_DONE;
            if (cmd_r == lpht_pkg::CMD_REM) begin
              ram_we    = 1'b1;
              ram_wdata = {lpht_pkg::SLOT_TOMB, rd_key, rd_val};
              count_nxt = count_r - 1'b1;
            end
          end else if (rd_st == lpht_pkg::SLOT_EMPTY || last) begin
            res_sts_nxt = lpht_pkg::STS_NF;
            state_nxt   = lpht_pkg::ST_DONE;
          end
        end
      end
      lpht_pkg::ST_DONE: begin
        cnt_nxt = '0;
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = res_sts_r;
          out_rd_nxt    = res_rd_r;
          out_cnt_nxt   = 9'(count_r);
          state_nxt     = lpht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/lpht_checker.sv @@
// Port-level checks for linear_probe_hash_table, bound to the top level.
// Depends on linear_probe_hash_table_assert.svh and lpht_pkg.
`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `LPHT_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "result beat changed while stalled")
  `LPHT_ASSERT(a_status,
    out_tvalid |-> out_tuser == lpht_pkg::STS_OK || out_tuser == lpht_pkg::STS_NF ||
      out_tuser == lpht_pkg::STS_FULL,
    "bad status")
  `LPHT_ASSERT(a_rd_zero,
    out_tvalid && out_tuser != lpht_pkg::STS_OK |-> out_tdata[31:0] == 32'd0,
    "read value on failed command")
  `LPHT_ASSERT_RST(a_reset, !rst_n |=> !out_tvalid && !in_tready, "activity straight after reset")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

@@ tb/linear_probe_hash_table_test.sv @@
// Self-checking testbench for linear_probe_hash_table: put/get/remove/clear beats
// checked against an in-bench table model. Needs lpht_pkg and the block's RTL.
`timescale 1ns / 100ps

module linear_probe_hash_table_test;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] val;
  } cmd_beat_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  live_count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wen = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  cmd_beat_t   pending_cmds[$];
  reply_t      replies_due[$];
  int          fails = 0;
  int unsigned cyc = 0;
  bit          calm = 1'b0;

  // table model
  logic [1:0]  slot_st [lpht_pkg::CAPACITY];
  logic [31:0] slot_k  [lpht_pkg::CAPACITY];
  logic [31:0] slot_v  [lpht_pkg::CAPACITY];
  int unsigned live_n, tomb_n, limit_n;

  linear_probe_hash_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned home_slot(input logic [31:0] key);
    logic [63:0] h;
    h = 64'd1469598103934665603;
    for (int b = 0; b < 4; b++) begin
      h = h ^ {56'd0, key[8*b +: 8]};
      h = h * 64'd1099511628211;
    end
    if (h == 64'd0) h = 64'd1;
    return 32'(h % lpht_pkg::CAPACITY);
  endfunction

  function automatic reply_t table_apply(input cmd_beat_t c);
    reply_t r;
    int unsigned home, s, tomb_at, target;
    bit have_tomb, done, got_empty;
    r.status = lpht_pkg::STS_OK;
    r.read_value = '0;
    home = home_slot(c.key);
    have_tomb = 0; done = 0; got_empty = 0; tomb_at = 0; target = 0;
    case (c.cmd)
      lpht_pkg::CMD_PUT: begin
        for (int i = 0; i < lpht_pkg::CAPACITY && !done && !got_empty; i++) begin
          s = (home + i) % lpht_pkg::CAPACITY;
          if (slot_st[s] == lpht_pkg::SLOT_USED) begin
            if (slot_k[s] == c.key) begin
              slot_v[s] = c.val;
              done = 1;
            end
          end else if (slot_st[s] == lpht_pkg::SLOT_TOMB) begin
            if (!have_tomb) begin
              have_tomb = 1;
              tomb_at = s;
            end
          end else begin
            got_empty = 1;
            target = s;
          end
        end
        if (!done) begin
          if (have_tomb) target = tomb_at;
          if (live_n >= limit_n || (!got_empty && !have_tomb)) begin
            r.status = lpht_pkg::STS_FULL;
          end else begin
            if (slot_st[target] == lpht_pkg::SLOT_TOMB) tomb_n--;
            slot_st[target] = lpht_pkg::SLOT_USED;
            slot_k[target] = c.key;
            slot_v[target] = c.val;
            live_n++;
          end
        end
      end
      lpht_pkg::CMD_GET, lpht_pkg::CMD_REM: begin
        r.status = lpht_pkg::STS_NF;
        for (int i = 0; i < lpht_pkg::CAPACITY && !done; i++) begin
          s = (home + i) % lpht_pkg::CAPACITY;
          if (slot_st[s] == lpht_pkg::SLOT_EMPTY) begin
            done = 1;
          end else if (slot_st[s] == lpht_pkg::SLOT_USED && slot_k[s] == c.key) begin
            done = 1;
            r.status = lpht_pkg::STS_OK;
            r.read_value = slot_v[s];
            if (c.cmd == lpht_pkg::CMD_REM) begin
              slot_st[s] = lpht_pkg::SLOT_TOMB;
              live_n--;
              tomb_n++;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < lpht_pkg::CAPACITY; i++) slot_st[i] = lpht_pkg::SLOT_EMPTY;
        live_n = 0;
        tomb_n = 0;
      end
    endcase
    r.live_count = live_n[8:0];
    return r;
  endfunction

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 22);
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    calm <= (cyc >= 4000 && cyc < 9000);
  end

  // driver
  always @(posedge clk) begin
    cmd_beat_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_cmds.size() > 0 && !idle_roll()) begin
        c = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {c.val, c.key};
        in_tuser  <= c.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // accepted commands go through the model
  always @(posedge clk) begin
    cmd_beat_t c;
    if (rst_n && in_tvalid && in_tready) begin
      c.cmd = in_tuser;
      c.key = in_tdata[31:0];
      c.val = in_tdata[63:32];
      replies_due.push_back(table_apply(c));
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected beat status=%0d value=%h count=%0d", $time,
                   out_tuser, out_tdata[31:0], out_tdata[40:32]);
          fails++;
        end else begin
          e = replies_due.pop_front();
          if (out_tuser !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_tuser);
            fails++;
          end
          if (out_tdata[31:0] !== e.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                     out_tdata[31:0]);
            fails++;
          end
          if (out_tdata[40:32] !== e.live_count) begin
            $display("%0t: live_count expected %0d actual %0d", $time, e.live_count,
                     out_tdata[40:32]);
            fails++;
          end
        end
      end
      out_tready <= !idle_roll();
    end
  end

  task automatic add(input logic [1:0] cmd, input logic [31:0] key, input logic [31:0] val);
    cmd_beat_t c;
    c.cmd = cmd;
    c.key = key;
    c.val = val;
    pending_cmds.push_back(c);
  endtask

  // sampled at the falling edge, once the driver's updates have settled
  task automatic drain();
    while (pending_cmds.size() > 0 || replies_due.size() > 0 || in_tvalid || !in_tready)
      @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_limit(input int unsigned v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v[8:0];
    limit_n = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [31:0] keys[64];
    int unsigned r, n;
    for (int i = 0; i < lpht_pkg::CAPACITY; i++) slot_st[i] = lpht_pkg::SLOT_EMPTY;
    live_n = 0; tomb_n = 0; limit_n = lpht_pkg::MAX_ENTRIES_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    add(lpht_pkg::CMD_PUT, 32'h0, 32'h0);
    add(lpht_pkg::CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
    add(lpht_pkg::CMD_GET, 32'h0, 32'h1234);
    add(lpht_pkg::CMD_GET, 32'hffff_ffff, 32'h0);
    add(lpht_pkg::CMD_PUT, 32'h0, 32'hdead_beef);
    add(lpht_pkg::CMD_GET, 32'h0, 32'h0);
    add(lpht_pkg::CMD_GET, 32'h5555_aaaa, 32'h0);
    add(lpht_pkg::CMD_REM, 32'hffff_ffff, 32'h0);
    add(lpht_pkg::CMD_REM, 32'hffff_ffff, 32'h0);
    add(lpht_pkg::CMD_GET, 32'hffff_ffff, 32'h0);
    add(lpht_pkg::CMD_PUT, 32'hffff_ffff, 32'h0bad_cafe);
    add(lpht_pkg::CMD_CLEAR, 32'h0, 32'h0);
    add(lpht_pkg::CMD_GET, 32'h0, 32'h0);
    drain();
    set_limit(0);
    add(lpht_pkg::CMD_PUT, 32'h1, 32'h1);
    add(lpht_pkg::CMD_REM, 32'h1, 32'h0);
    drain();
    set_limit(2);
    add(lpht_pkg::CMD_PUT, 32'h10, 32'haaaa_aaaa);
    add(lpht_pkg::CMD_PUT, 32'h20, 32'h5555_5555);
    add(lpht_pkg::CMD_PUT, 32'h30, 32'h1);
    add(lpht_pkg::CMD_PUT, 32'h10, 32'h7777_7777);
    add(lpht_pkg::CMD_GET, 32'h10, 32'h0);
    add(lpht_pkg::CMD_CLEAR, 32'h0, 32'h0);
    drain();

    // fill every slot, then full, tombstone reuse and long probes
    set_limit(511);
    for (int i = 0; i < lpht_pkg::CAPACITY; i++)
      add(lpht_pkg::CMD_PUT, i * 32'h0101_0007 + 3, $urandom());
    add(lpht_pkg::CMD_PUT, 32'h8000_0000, 32'h1);
    for (int i = 0; i < 8; i++)
      add(lpht_pkg::CMD_GET, $urandom_range(lpht_pkg::CAPACITY - 1) * 32'h0101_0007 + 3, 0);
    add(lpht_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    for (int i = 0; i < 6; i++) add(lpht_pkg::CMD_REM, (i * 37) * 32'h0101_0007 + 3, 0);
    add(lpht_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    add(lpht_pkg::CMD_PUT, 32'h8000_0000, 32'h2);
    add(lpht_pkg::CMD_PUT, 32'h8000_0001, 32'h3);
    add(lpht_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    drain();
    set_limit(256);
    add(lpht_pkg::CMD_PUT, 32'h9000_0000, 32'h4);
    add(lpht_pkg::CMD_CLEAR, 32'h0, 32'h0);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_limit(lpht_pkg::MAX_ENTRIES_RST);
        1: set_limit(40);
        2: set_limit(256);
        default: set_limit($urandom_range(511));
      endcase
      for (int i = 0; i < 64; i++) keys[i] = $urandom();
      n = (ph == 0) ? 48 : 64;
      for (int i = 0; i < 400; i++) begin
        r = $urandom_range(99);
        if (r < 45)      add(lpht_pkg::CMD_PUT, keys[$urandom_range(n - 1)], $urandom());
        else if (r < 70) add(lpht_pkg::CMD_GET, keys[$urandom_range(n - 1)], $urandom());
        else if (r < 90) add(lpht_pkg::CMD_REM, keys[$urandom_range(n - 1)], $urandom());
        else if (r < 98) add(2'($urandom_range(2)), $urandom(), $urandom());
        else             add(lpht_pkg::CMD_CLEAR, $urandom(), $urandom());
      end
      drain();
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ linear_probe_hash_table.f @@
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/linear_probe_hash_table.sv
hw/rtl/lpht_checker.sv
tb/linear_probe_hash_table_test.sv
